/* hdl/crc32bsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32bsc_pkg: shared types and constants of the CRC-32 byte stream checker
// Register map, field widths and the step result that the byte step hands
// to the top level.
// ----------------------------------------------------------------------------
package crc32bsc_pkg;

	localparam int CRC_W   = 32;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 3;
	localparam int ADDR_W  = 3;

	// number of bytes loaded raw before the register is inverted
	localparam logic [COUNT_W-1:0] SEED_BYTES = 3'd4;

	localparam logic [CRC_W-1:0] POLY_RESET = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0] TOP_BIT    = 32'h8000_0000;

	// register indexes (byte address bits above the word offset)
	localparam logic [ADDR_W-3:0] REG_POLY = 1'b0;

	// next state and optional result of one byte
	typedef struct packed {
		logic [CRC_W-1:0]   remainder;
		logic [COUNT_W-1:0] count;
		logic               result_valid;
		logic [CRC_W-1:0]   crc_value;
		logic               too_short;
	} step_result_t;

endpackage

/* hdl/crc32bsc_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32bsc_cfg_regs: APB register file
// Holds the generator polynomial; writes complete in the access phase,
// reads return the register value, the port never waits.
// ----------------------------------------------------------------------------
module crc32bsc_cfg_regs (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [crc32bsc_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	output logic [crc32bsc_pkg::CRC_W-1:0]         polynomial
);

	logic [crc32bsc_pkg::CRC_W-1:0] poly_q;
	logic [crc32bsc_pkg::ADDR_W-3:0] reg_index;
	logic                            wr_en;

	assign pready    = 1'b1;
	assign reg_index = paddr[crc32bsc_pkg::ADDR_W-1:2];
	assign wr_en     = psel && penable && pwrite && pready;

	// write the polynomial on a completed access to its address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= crc32bsc_pkg::POLY_RESET;
		end else if (wr_en && (reg_index == crc32bsc_pkg::REG_POLY)) begin
			poly_q <= pwdata;
		end
	end

	// decode read data
	always_comb begin
		case (reg_index)
			crc32bsc_pkg::REG_POLY: prdata = poly_q;
			default:                prdata = 32'h0;
		endcase
	end

	assign polynomial = poly_q;

endmodule

/* hdl/crc32bsc_byte_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32bsc_byte_step: one byte of the CRC recurrence
// Seeds the register with the first four bytes, then folds each further byte
// in through the table value of the outgoing top byte. On the last byte it
// forms the result and clears the state.
// ----------------------------------------------------------------------------
module crc32bsc_byte_step (
	input  logic [crc32bsc_pkg::CRC_W-1:0]   remainder,
	input  logic [crc32bsc_pkg::COUNT_W-1:0] count,
	input  logic [crc32bsc_pkg::BYTE_W-1:0]  data_byte,
	input  logic                             last_byte,
	input  logic [crc32bsc_pkg::CRC_W-1:0]   polynomial,
	output crc32bsc_pkg::step_result_t       step
);

	// divide the top byte MSB first by the polynomial, eight bit steps
	function automatic logic [crc32bsc_pkg::CRC_W-1:0] table_value(
		input logic [crc32bsc_pkg::BYTE_W-1:0] top_byte,
		input logic [crc32bsc_pkg::CRC_W-1:0]  poly
	);
		logic [crc32bsc_pkg::CRC_W-1:0] r;
		r = {top_byte, 24'h0};
		for (int k = 0; k < crc32bsc_pkg::BYTE_W; k++) begin
			if ((r & crc32bsc_pkg::TOP_BIT) != '0) begin
				r = (r << 1) ^ poly;
			end else begin
				r = r << 1;
			end
		end
		return r;
	endfunction

	logic [crc32bsc_pkg::CRC_W-1:0]   shifted;
	logic [crc32bsc_pkg::CRC_W-1:0]   rem_next;
	logic [crc32bsc_pkg::COUNT_W-1:0] count_next;
	logic                             short_msg;

	assign shifted = {remainder[crc32bsc_pkg::CRC_W-9:0], data_byte};

	// advance the register and the saturating byte count
	always_comb begin
		if (count < crc32bsc_pkg::SEED_BYTES) begin
			count_next = count + 3'd1;
			rem_next   = (count_next == crc32bsc_pkg::SEED_BYTES) ? ~shifted : shifted;
		end else begin
			count_next = count;
			rem_next   = shifted ^ table_value(remainder[crc32bsc_pkg::CRC_W-1 -: 8],
				polynomial);
		end
	end

	assign short_msg = (count_next < crc32bsc_pkg::SEED_BYTES);

	// form the result on the last byte and clear the state
	always_comb begin
		step.result_valid = last_byte;
		step.too_short    = short_msg;
		step.crc_value    = short_msg ? '0 : ~rem_next;
		if (last_byte) begin
			step.remainder = '0;
			step.count     = '0;
		end else begin
			step.remainder = rem_next;
			step.count     = count_next;
		end
	end

endmodule

/* hdl/crc32_byte_stream_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_byte_stream_checker: CRC-32 (MSB first, inverted seed and result) check of a byte stream
// Registers each byte, runs one table step against the running remainder
// and registers the CRC of a message when its last byte goes through.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    data_byte, last_byte
//   out      source     out_valid / out_stall  crc_value, too_short
//   cfg      APB slave  psel/penable/pready    polynomial at address 0
//
// One byte per cycle sustained unless a last byte waits on a full, stalled
// result register; a result passes the input register, the single table
// step and the result register in that order.
// Reset clears the remainder, the byte count and both valid flags and loads
// the default polynomial 0x04C11DB7.
// A stalled result holds; only a last byte waiting on a full, stalled result
// register stalls the input.
// ----------------------------------------------------------------------------
module crc32_byte_stream_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [crc32bsc_pkg::BYTE_W-1:0]        data_byte,
	input  logic                                   last_byte,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [crc32bsc_pkg::CRC_W-1:0]         crc_value,
	output logic                                   too_short,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [crc32bsc_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);

	logic [crc32bsc_pkg::CRC_W-1:0]   polynomial;
	logic                             valid_s1;
	logic [crc32bsc_pkg::BYTE_W-1:0]  data_s1;
	logic                             last_s1;
	logic                             out_valid_s2;
	logic [crc32bsc_pkg::CRC_W-1:0]   crc_s2;
	logic                             short_s2;
	logic [crc32bsc_pkg::CRC_W-1:0]   remainder_q;
	logic [crc32bsc_pkg::COUNT_W-1:0] count_q;
	crc32bsc_pkg::step_result_t       step;
	logic                             advance;
	logic                             in_accept;

	crc32bsc_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.polynomial (polynomial)
	);

	crc32bsc_byte_step u_step (
		.remainder  (remainder_q),
		.count      (count_q),
		.data_byte  (data_s1),
		.last_byte  (last_s1),
		.polynomial (polynomial),
		.step       (step)
	);

	// a byte moves on unless it needs the result register and that is blocked
	assign advance   = valid_s1 && (!last_s1 || !out_valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// running remainder and byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remainder_q <= '0;
			count_q     <= '0;
		end else if (advance) begin
			remainder_q <= step.remainder;
			count_q     <= step.count;
		end
	end

	// result register: load on a last byte, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance && step.result_valid) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.result_valid) begin
			crc_s2   <= step.crc_value;
			short_s2 <= step.too_short;
		end
	end

	assign out_valid = out_valid_s2;
	assign crc_value = crc_s2;
	assign too_short = short_s2;

	// a short message reports a zero CRC
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && short_s2 |-> crc_s2 == '0)
		else $error("too_short result with nonzero crc_value");

	// the byte count saturates at the seed length
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= crc32bsc_pkg::SEED_BYTES)
		else $error("byte count beyond seed length");

	// input stalls only behind a last byte blocked by a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && last_s1 && out_valid_s2 && out_stall)
		else $error("input stalled without a blocked last byte");

	// the end of a message clears the state and presents a result
	a_msg_end: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> count_q == '0 && remainder_q == '0 && out_valid_s2)
		else $error("state not cleared after last byte");

endmodule
